// ===== hdl/dhfr_pkg.sv =====
package dhfr_pkg;

  localparam int STORE_BYTES = 64;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 24;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 3;

  localparam int LIMIT_CAP_I = (56 < STORE_BYTES - 1) ? 56 : STORE_BYTES - 1;
  localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(LIMIT_CAP_I);
  localparam logic [CNT_W-1:0] LIMIT_RST = 6'd56;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRI_HDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_HDR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRI_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_LIMIT = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic start;       // open a new frame, latch kind
    logic kind;        // kind for start
    logic store;       // write rx byte at the fill position
    logic drain_start; // rewind read pointer
    logic issue;       // read one stored byte toward the output
  } dhfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic m_pri0;
    logic m_alt0;
    logic m_hdr1;
    logic m_hdr2;
    logic m_tail0;
    logic m_tail1;
    logic m_tail2;
    logic below_limit;
    logic can_issue;
    logic rd_last;
  } dhfr_sts_t;

endpackage

// ===== hdl/dual_header_frame_receiver_unit.sv =====
// Frame receiver for a byte stream with two header kinds. Each input word is one received
// byte. A frame opens with the three bytes of the primary or the alternate header (primary
// wins if both first bytes match), the byte after the header is dropped, then data bytes are
// kept until the first tail byte, which is kept too; the second tail byte is kept and the third
// closes the frame without being kept. Any mismatch, or a data byte at the kind's limit, drops
// back to idle; that byte is not re-examined as a header start. A closed frame is sent out as
// one output word per kept byte with kind, position and a last mark on the final byte.
// Rate: outside a drain one input word is taken per cycle. When a frame closes, in_ready
// drops for the drain, which reads the frame store once per output word with one read in
// flight at a time (RAM read, then output register), up to 57 kept bytes for the longest
// frame, and waits while out_ready is low. The store needs no clearing pass after reset.
// Configuration words are accepted in every cycle; write them only while the block is idle.
module dual_header_frame_receiver_unit
  import dhfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  // received bytes
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  // frame bytes
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_frame_kind,
  output logic [CNT_W-1:0]     out_byte_position,
  output logic [BYTE_W-1:0]    out_frame_byte,
  output logic                 out_last_byte
);

  dhfr_cmd_t cmd;
  dhfr_sts_t sts;

  // registers take a write in every cycle
  assign cfg_ready = 1'b1;

  // sequence the parse and the drain
  dhfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold registers, compare bytes, store the frame and drive the output word
  dhfr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_kind    (out_frame_kind),
    .out_byte_position (out_byte_position),
    .out_frame_byte    (out_frame_byte),
    .out_last_byte     (out_last_byte)
  );

endmodule

// ===== hdl/dhfr_ram.sv =====
module dhfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dhfr_ctrl.sv =====
module dhfr_ctrl
  import dhfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dhfr_sts_t sts,
  output dhfr_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_HDR1  = 4'd1;
  localparam logic [3:0] ST_HDR2  = 4'd2;
  localparam logic [3:0] ST_SKIP  = 4'd3;
  localparam logic [3:0] ST_DATA  = 4'd4;
  localparam logic [3:0] ST_TAIL1 = 4'd5;
  localparam logic [3:0] ST_TAIL2 = 4'd6;
  localparam logic [3:0] ST_DRAIN = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       in_fire;

  assign in_ready = (state_r != ST_DRAIN);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (sts.m_pri0) begin
            cmd.start = 1'b1;
            cmd.store = 1'b1;
            state_nxt = ST_HDR1;
          end else if (sts.m_alt0) begin
            cmd.start = 1'b1;
            cmd.kind  = 1'b1;
            cmd.store = 1'b1;
            state_nxt = ST_HDR1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_HDR1: begin
        if (in_fire) begin
          cmd.store = sts.m_hdr1;
          state_nxt = sts.m_hdr1 ? ST_HDR2 : ST_IDLE;
        end
      end
      ST_HDR2: begin
        if (in_fire) begin
          cmd.store = sts.m_hdr2;
          state_nxt = sts.m_hdr2 ? ST_SKIP : ST_IDLE;
        end
      end
      ST_SKIP: begin
        if (in_fire) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          if (sts.below_limit) begin
            cmd.store = 1'b1;
            state_nxt = sts.m_tail0 ? ST_TAIL1 : ST_DATA;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TAIL1: begin
        if (in_fire) begin
          cmd.store = sts.m_tail1;
          state_nxt = sts.m_tail1 ? ST_TAIL2 : ST_IDLE;
        end
      end
      ST_TAIL2: begin
        if (in_fire) begin
          cmd.drain_start = sts.m_tail2;
          state_nxt       = sts.m_tail2 ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (sts.can_issue) begin
          cmd.issue = 1'b1;
          if (sts.rd_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/dhfr_datapath.sv =====
module dhfr_datapath
  import dhfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  input  dhfr_cmd_t            cmd,
  output dhfr_sts_t            sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_frame_kind,
  output logic [CNT_W-1:0]     out_byte_position,
  output logic [BYTE_W-1:0]    out_frame_byte,
  output logic                 out_last_byte
);

  logic [WORD_W-1:0] pri_hdr_r, alt_hdr_r, tail_r;
  logic [CNT_W-1:0]  pri_lim_r, alt_lim_r;
  logic              kind_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  rd_ptr_r;
  logic              pend_r;
  logic [CNT_W-1:0]  pend_pos_r;
  logic              pend_last_r;
  logic              out_valid_r;
  logic              out_kind_r;
  logic [CNT_W-1:0]  out_pos_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [WORD_W-1:0] hdr;
  logic [CNT_W-1:0]  lim, eff_lim;
  logic [CNT_W-1:0]  wr_pos;
  logic [BYTE_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pri_hdr_r <= '0;
      alt_hdr_r <= '0;
      tail_r    <= '0;
      pri_lim_r <= LIMIT_RST;
      alt_lim_r <= LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRI_HDR:   pri_hdr_r <= cfg_data;
        REG_ALT_HDR:   alt_hdr_r <= cfg_data;
        REG_TAIL:      tail_r    <= cfg_data;
        REG_PRI_LIMIT: pri_lim_r <= cfg_data[CNT_W-1:0];
        REG_ALT_LIMIT: alt_lim_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // byte compares and limit check
  assign hdr     = kind_r ? alt_hdr_r : pri_hdr_r;
  assign lim     = kind_r ? alt_lim_r : pri_lim_r;
  assign eff_lim = (lim > LIMIT_CAP) ? LIMIT_CAP : lim;

  always_comb begin
    sts             = '0;
    sts.m_pri0      = (in_rx_byte == pri_hdr_r[23:16]);
    sts.m_alt0      = (in_rx_byte == alt_hdr_r[23:16]);
    sts.m_hdr1      = (in_rx_byte == hdr[15:8]);
    sts.m_hdr2      = (in_rx_byte == hdr[7:0]);
    sts.m_tail0     = (in_rx_byte == tail_r[23:16]);
    sts.m_tail1     = (in_rx_byte == tail_r[15:8]);
    sts.m_tail2     = (in_rx_byte == tail_r[7:0]);
    sts.below_limit = (count_r < eff_lim);
    sts.can_issue   = !pend_r && (!out_valid_r || out_ready);
    sts.rd_last     = (rd_ptr_r == count_r - CNT_W'(1));
  end

  // fill position restarts at zero with the first header byte
  assign wr_pos = cmd.start ? '0 : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= 1'b0;
      count_r <= '0;
    end else begin
      if (cmd.start) begin
        kind_r <= cmd.kind;
      end
      if (cmd.store) begin
        count_r <= wr_pos + CNT_W'(1);
      end
    end
  end

  dhfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (ADDR_W'(wr_pos)),
    .wdata (in_rx_byte),
    .raddr (ADDR_W'(rd_ptr_r)),
    .rdata (ram_rdata)
  );

  // drain: issue a read, take the RAM data into the output register next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.drain_start) begin
        rd_ptr_r <= '0;
      end else if (cmd.issue) begin
        rd_ptr_r <= rd_ptr_r + CNT_W'(1);
      end
      pend_r <= cmd.issue;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      pend_pos_r  <= rd_ptr_r;
      pend_last_r <= sts.rd_last;
    end
    if (pend_r) begin
      out_kind_r <= kind_r;
      out_pos_r  <= pend_pos_r;
      out_byte_r <= ram_rdata;
      out_last_r <= pend_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_kind    = out_kind_r;
  assign out_byte_position = out_pos_r;
  assign out_frame_byte    = out_byte_r;
  assign out_last_byte     = out_last_r;

  // read data lands only in a free output register
  a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !out_valid_r || $past(out_ready))
    else $error("read data would overwrite a waiting output word");

  // one read in flight at a time
  a_issue_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !pend_r)
    else $error("read issued while another is pending");

  // fill position never passes the store
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> int'(wr_pos) < STORE_BYTES)
    else $error("store write beyond capacity");

  // a new frame and a drain never start together
  a_start_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.start && (cmd.drain_start || cmd.issue)))
    else $error("frame start collides with drain");

endmodule
